FILE: hw/rtl/ssmv_pkg.sv
package ssmv_pkg;

  // Sample handling
  localparam int MAX_READINGS = 65536;
  localparam int SAMPLE_WIDTH = 16;
  localparam int READING_W    = 16;
  localparam int CNT_W        = $clog2(MAX_READINGS + 1);

  // Accumulator widths, sized for 16-bit readings and up to 65536 of them
  localparam int SUM_W  = 33;
  localparam int ABS_W  = 32;
  localparam int SSQ_W  = 47;
  localparam int SQ_W   = 31;

  // Shared multiplier and divider
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DIV_W  = 64;
  localparam int DVS_W  = 34;
  localparam int DCNT_W = $clog2(DIV_W);
  localparam int VAR_W  = 31;

  typedef enum logic [1:0] {
    MUL_SUM_SQ,
    MUL_N_LO,
    MUL_N_HI,
    MUL_N_NM1
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_ACC,
    ST_ABS,
    ST_MB,
    ST_ML,
    ST_MH,
    ST_MD,
    ST_NUM,
    ST_DIVM,
    ST_WAITM,
    ST_DIVV,
    ST_WAITV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic     acc_en;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     b_load;
    logic     a_lo_load;
    logic     a_hi_add;
    logic     num_load;
    logic     div_start;
    logic     div_var;
    logic     mean_load;
    logic     var_load;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: hw/rtl/ssmv_div.sv
module ssmv_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [ssmv_pkg::DIV_W-1:0]       dividend,
  input  logic [ssmv_pkg::DVS_W-1:0]       divisor,
  output logic                             busy,
  output logic                             done,
  output logic [ssmv_pkg::DIV_W-1:0]       quotient
);

  logic [ssmv_pkg::DVS_W-1:0]  rem_r;
  logic [ssmv_pkg::DIV_W-1:0]  quo_r;
  logic [ssmv_pkg::DVS_W-1:0]  dvs_r;
  logic [ssmv_pkg::DCNT_W-1:0] cnt_r;
  logic                        busy_r;
  logic                        done_r;

  logic [ssmv_pkg::DVS_W:0]    shifted;
  logic [ssmv_pkg::DVS_W:0]    diff;
  logic                        ge;
  logic                        last_step;

  // Restoring division, one quotient bit per cycle
  assign shifted   = {rem_r, quo_r[ssmv_pkg::DIV_W-1]};
  assign diff      = shifted - {1'b0, dvs_r};
  assign ge        = shifted >= {1'b0, dvs_r};
  assign last_step = cnt_r == ssmv_pkg::DCNT_W'(ssmv_pkg::DIV_W - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last_step;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last_step) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[ssmv_pkg::DVS_W-1:0] : shifted[ssmv_pkg::DVS_W-1:0];
      quo_r <= {quo_r[ssmv_pkg::DIV_W-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: hw/rtl/ssmv_dp.sv
module ssmv_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ssmv_pkg::dp_cmd_t                     cmd,
  output ssmv_pkg::dp_sts_t                     sts,
  input  logic                                  in_valid,
  input  logic signed [ssmv_pkg::READING_W-1:0] in_reading,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [ssmv_pkg::READING_W-1:0] out_min_value,
  output logic signed [ssmv_pkg::READING_W-1:0] out_max_value,
  output logic signed [ssmv_pkg::READING_W-1:0] out_mean_value,
  output logic [ssmv_pkg::VAR_W-1:0]            out_sample_variance,
  output logic [ssmv_pkg::CNT_W-1:0]            out_reading_count,
  output logic                                  out_overflowed
);

  // Accumulators
  logic [ssmv_pkg::CNT_W-1:0]            cnt_r;
  logic signed [ssmv_pkg::READING_W-1:0] min_r;
  logic signed [ssmv_pkg::READING_W-1:0] max_r;
  logic signed [ssmv_pkg::SUM_W-1:0]     sum_r;
  logic [ssmv_pkg::SSQ_W-1:0]            ssq_r;
  logic [ssmv_pkg::SQ_W-1:0]             sq_r;
  logic                                  sq_pend_r;
  logic                                  drop_r;

  // Finishing datapath
  logic [ssmv_pkg::ABS_W-1:0]            abs_sum_r;
  logic                                  neg_r;
  logic [ssmv_pkg::PROD_W-1:0]           prod_r;
  logic [ssmv_pkg::PROD_W-1:0]           a_r;
  logic [ssmv_pkg::PROD_W-1:0]           b_r;
  logic [ssmv_pkg::DIV_W-1:0]            num_r;
  logic [ssmv_pkg::DVS_W-1:0]            den_r;
  logic signed [ssmv_pkg::READING_W-1:0] mean_r;
  logic [ssmv_pkg::VAR_W-1:0]            var_r;

  // Result register
  logic                                  out_valid_r;
  logic signed [ssmv_pkg::READING_W-1:0] out_min_r;
  logic signed [ssmv_pkg::READING_W-1:0] out_max_r;
  logic signed [ssmv_pkg::READING_W-1:0] out_mean_r;
  logic [ssmv_pkg::VAR_W-1:0]            out_var_r;
  logic [ssmv_pkg::CNT_W-1:0]            out_cnt_r;
  logic                                  out_ovf_r;

  logic signed [ssmv_pkg::READING_W-1:0] x;
  logic signed [2*ssmv_pkg::READING_W-1:0] x_sq;
  logic                                  accept;
  logic                                  room;
  logic [ssmv_pkg::SUM_W-1:0]            sum_abs;
  logic [ssmv_pkg::MUL_W-1:0]            op_a;
  logic [ssmv_pkg::MUL_W-1:0]            op_b;
  logic [ssmv_pkg::DIV_W-1:0]            div_dividend;
  logic [ssmv_pkg::DVS_W-1:0]            div_divisor;
  logic [ssmv_pkg::DIV_W-1:0]            div_q;
  logic                                  div_busy;
  logic                                  div_done;

  // Only the low SAMPLE_WIDTH bits count, as a two's complement value
  assign x      = ssmv_pkg::READING_W'($signed(in_reading[ssmv_pkg::SAMPLE_WIDTH-1:0]));
  assign x_sq   = x * x;
  assign accept = in_valid && cmd.acc_en;
  assign room   = cnt_r != ssmv_pkg::CNT_W'(ssmv_pkg::MAX_READINGS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      min_r     <= '0;
      max_r     <= '0;
      sum_r     <= '0;
      ssq_r     <= '0;
      sq_pend_r <= 1'b0;
      drop_r    <= 1'b0;
    end else if (cmd.out_load) begin
      cnt_r     <= '0;
      min_r     <= '0;
      max_r     <= '0;
      sum_r     <= '0;
      ssq_r     <= '0;
      sq_pend_r <= 1'b0;
      drop_r    <= 1'b0;
    end else begin
      sq_pend_r <= accept && room;
      // square is summed into ssq_r in the cycle after its reading is taken
      if (sq_pend_r) begin
        ssq_r <= ssq_r + ssmv_pkg::SSQ_W'(sq_r);
      end
      if (accept) begin
        if (room) begin
          cnt_r <= cnt_r + 1'b1;
          sum_r <= sum_r + ssmv_pkg::SUM_W'(x);
          if (cnt_r == '0) begin
            min_r <= x;
            max_r <= x;
          end else begin
            if (x < min_r) min_r <= x;
            if (x > max_r) max_r <= x;
          end
        end else begin
          drop_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && room) begin
      sq_r <= x_sq[ssmv_pkg::SQ_W-1:0];
    end
  end

  // Magnitude of the sum, tracked every cycle
  assign sum_abs = sum_r[ssmv_pkg::SUM_W-1] ? -sum_r : sum_r;

  always_ff @(posedge clk) begin
    abs_sum_r <= sum_abs[ssmv_pkg::ABS_W-1:0];
    neg_r     <= sum_r[ssmv_pkg::SUM_W-1];
  end

  // Shared 32x32 multiplier
  always_comb begin
    unique case (cmd.mul_sel)
      ssmv_pkg::MUL_SUM_SQ: begin
        op_a = abs_sum_r;
        op_b = abs_sum_r;
      end
      ssmv_pkg::MUL_N_LO: begin
        op_a = ssmv_pkg::MUL_W'(cnt_r);
        op_b = ssq_r[ssmv_pkg::MUL_W-1:0];
      end
      ssmv_pkg::MUL_N_HI: begin
        op_a = ssmv_pkg::MUL_W'(cnt_r);
        op_b = ssmv_pkg::MUL_W'(ssq_r[ssmv_pkg::SSQ_W-1:ssmv_pkg::MUL_W]);
      end
      ssmv_pkg::MUL_N_NM1: begin
        op_a = ssmv_pkg::MUL_W'(cnt_r);
        op_b = ssmv_pkg::MUL_W'(cnt_r - 1'b1);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= op_a * op_b;
    end
    if (cmd.b_load) begin
      b_r <= prod_r;
    end
    if (cmd.a_lo_load) begin
      a_r <= prod_r;
    end else if (cmd.a_hi_add) begin
      a_r <= a_r + {prod_r[ssmv_pkg::MUL_W-1:0], {ssmv_pkg::MUL_W{1'b0}}};
    end
    if (cmd.num_load) begin
      num_r <= (a_r >= b_r) ? ssmv_pkg::DIV_W'(a_r - b_r) : '0;
      den_r <= prod_r[ssmv_pkg::DVS_W-1:0];
    end
  end

  assign div_dividend = cmd.div_var ? num_r : ssmv_pkg::DIV_W'(abs_sum_r);
  assign div_divisor  = cmd.div_var ? den_r : ssmv_pkg::DVS_W'(cnt_r);

  ssmv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.mean_load) begin
      mean_r <= neg_r ? -div_q[ssmv_pkg::READING_W-1:0] : div_q[ssmv_pkg::READING_W-1:0];
    end
    if (cmd.var_load) begin
      if (cnt_r <= ssmv_pkg::CNT_W'(1)) begin
        var_r <= '0;
      end else if (|div_q[ssmv_pkg::DIV_W-1:ssmv_pkg::VAR_W]) begin
        var_r <= '1;
      end else begin
        var_r <= div_q[ssmv_pkg::VAR_W-1:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_min_r  <= min_r;
      out_max_r  <= max_r;
      out_mean_r <= mean_r;
      out_var_r  <= var_r;
      out_cnt_r  <= cnt_r;
      out_ovf_r  <= drop_r;
    end
  end

  assign sts.div_busy = div_busy;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid           = out_valid_r;
  assign out_min_value       = out_min_r;
  assign out_max_value       = out_max_r;
  assign out_mean_value      = out_mean_r;
  assign out_sample_variance = out_var_r;
  assign out_reading_count   = out_cnt_r;
  assign out_overflowed      = out_ovf_r;

`ifndef SYNTHESIS
  a_minmax_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> (min_r <= max_r))
    else $error("running min above running max");

  a_square_landed: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !sq_pend_r)
    else $error("result loaded before last square was summed");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !room) |=> (drop_r && (cnt_r == $past(cnt_r))))
    else $error("reading taken beyond capacity");
`endif

endmodule

FILE: hw/rtl/ssmv_ctrl.sv
module ssmv_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_stall,
  input  ssmv_pkg::dp_sts_t sts,
  output ssmv_pkg::dp_cmd_t cmd
);

  ssmv_pkg::state_t state_r;
  ssmv_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssmv_pkg::ST_ACC;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.mul_sel = ssmv_pkg::MUL_SUM_SQ;
    unique case (state_r)
      ssmv_pkg::ST_ACC: begin
        cmd.acc_en = 1'b1;
        if (in_valid && in_last) state_nxt = ssmv_pkg::ST_ABS;
      end
      // sum magnitude and final square settle
      ssmv_pkg::ST_ABS: state_nxt = ssmv_pkg::ST_MB;
      ssmv_pkg::ST_MB: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = ssmv_pkg::MUL_SUM_SQ;
        state_nxt   = ssmv_pkg::ST_ML;
      end
      ssmv_pkg::ST_ML: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = ssmv_pkg::MUL_N_LO;
        cmd.b_load  = 1'b1;
        state_nxt   = ssmv_pkg::ST_MH;
      end
      ssmv_pkg::ST_MH: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = ssmv_pkg::MUL_N_HI;
        cmd.a_lo_load = 1'b1;
        state_nxt     = ssmv_pkg::ST_MD;
      end
      ssmv_pkg::ST_MD: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = ssmv_pkg::MUL_N_NM1;
        cmd.a_hi_add = 1'b1;
        state_nxt    = ssmv_pkg::ST_NUM;
      end
      ssmv_pkg::ST_NUM: begin
        cmd.num_load = 1'b1;
        state_nxt    = ssmv_pkg::ST_DIVM;
      end
      ssmv_pkg::ST_DIVM: begin
        cmd.div_start = 1'b1;
        state_nxt     = ssmv_pkg::ST_WAITM;
      end
      ssmv_pkg::ST_WAITM: begin
        if (sts.div_done) begin
          cmd.mean_load = 1'b1;
          state_nxt     = ssmv_pkg::ST_DIVV;
        end
      end
      ssmv_pkg::ST_DIVV: begin
        cmd.div_start = 1'b1;
        cmd.div_var   = 1'b1;
        state_nxt     = ssmv_pkg::ST_WAITV;
      end
      ssmv_pkg::ST_WAITV: begin
        if (sts.div_done) begin
          cmd.var_load = 1'b1;
          state_nxt    = ssmv_pkg::ST_OUT;
        end
      end
      ssmv_pkg::ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ssmv_pkg::ST_ACC;
        end
      end
      default: state_nxt = ssmv_pkg::ST_ACC;
    endcase
  end

  assign in_stall = !cmd.acc_en;

`ifndef SYNTHESIS
  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider started while busy");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result register overwritten");

  a_last_ends_list: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ssmv_pkg::ST_ACC && in_valid && in_last) |=> in_stall)
    else $error("input taken after last transaction of a list");
`endif

endmodule

FILE: hw/rtl/sample_stats_min_max_mean_var_core.sv
// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall  in_reading (s16 Q8.8), in_last
// out_     output     out_valid/out_stall  out_min_value, out_max_value, out_mean_value,
//                                          out_sample_variance, out_reading_count,
//                                          out_overflowed
//
// Readings that are not the last of a list go in at one per cycle.
// A last transaction starts the finishing sequence: the 64-step divider run twice
// (mean, then variance) behind four passes of one 32x32 multiplier. in_stall stays
// high until the result is loaded into the output register.
// Reset (rst_n low, synchronous) empties the accumulators and the result register.
// A stalled result waits in the output register; a new list is taken meanwhile,
// and the next result waits until that register frees up.
module sample_stats_min_max_mean_var_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [ssmv_pkg::READING_W-1:0] in_reading,
  input  logic                                  in_last,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [ssmv_pkg::READING_W-1:0] out_min_value,
  output logic signed [ssmv_pkg::READING_W-1:0] out_max_value,
  output logic signed [ssmv_pkg::READING_W-1:0] out_mean_value,
  output logic [ssmv_pkg::VAR_W-1:0]            out_sample_variance,
  output logic [ssmv_pkg::CNT_W-1:0]            out_reading_count,
  output logic                                  out_overflowed
);

  // Controller sequences the finishing math; datapath holds accumulators,
  // multiplier, divider and result register.
  ssmv_pkg::dp_cmd_t cmd;
  ssmv_pkg::dp_sts_t sts;

  ssmv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ssmv_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_valid            (in_valid),
    .in_reading          (in_reading),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_min_value       (out_min_value),
    .out_max_value       (out_max_value),
    .out_mean_value      (out_mean_value),
    .out_sample_variance (out_sample_variance),
    .out_reading_count   (out_reading_count),
    .out_overflowed      (out_overflowed)
  );

endmodule

FILE: tb/tb_sample_stats_min_max_mean_var_core.sv
`timescale 1ns / 1ps

// Checks sample_stats_min_max_mean_var_core against a behavioral model of the
// list statistics: min, max, truncated mean, sample variance, count, drop flag.
// Inputs change on the falling edge; handshakes and results are sampled on the
// rising edge.
module tb_sample_stats_min_max_mean_var_core;

  localparam int RANDOM_ITEMS = 1000;
  localparam int CYCLE_LIMIT  = 2_000_000;  // leaves room even if every reading ends a list
  localparam int DRAIN_CYCLES = 200;
  localparam int MAX_REPORTS  = 10;

  // One statistics result, laid out as the output ports
  typedef struct packed {
    logic signed [ssmv_pkg::READING_W-1:0] min_v;
    logic signed [ssmv_pkg::READING_W-1:0] max_v;
    logic signed [ssmv_pkg::READING_W-1:0] mean_v;
    logic [ssmv_pkg::VAR_W-1:0]            var_v;
    logic [ssmv_pkg::CNT_W-1:0]            count_v;
    logic                                  ovf;
  } stats_t;

  logic                                  clk = 1'b0;
  logic                                  rst_n;
  logic                                  in_valid;
  logic                                  in_stall;
  logic signed [ssmv_pkg::READING_W-1:0] in_reading;
  logic                                  in_last;
  logic                                  out_valid;
  logic                                  out_stall;
  logic signed [ssmv_pkg::READING_W-1:0] out_min_value;
  logic signed [ssmv_pkg::READING_W-1:0] out_max_value;
  logic signed [ssmv_pkg::READING_W-1:0] out_mean_value;
  logic [ssmv_pkg::VAR_W-1:0]            out_sample_variance;
  logic [ssmv_pkg::CNT_W-1:0]            out_reading_count;
  logic                                  out_overflowed;

  sample_stats_min_max_mean_var_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_reading          (in_reading),
    .in_last             (in_last),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_min_value       (out_min_value),
    .out_max_value       (out_max_value),
    .out_mean_value      (out_mean_value),
    .out_sample_variance (out_sample_variance),
    .out_reading_count   (out_reading_count),
    .out_overflowed      (out_overflowed)
  );

  // 2 ns period
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------------
  // Statistics model: accumulators of the list in progress
  // ---------------------------------------------------------------------------
  int          acc_count;
  int          acc_min;
  int          acc_max;
  longint      acc_sum;
  bit [63:0]   acc_ssq;
  bit          acc_dropped;

  stats_t      expected_stats[$];   // one entry per list closed by a last reading

  int          readings_sent;
  int          lists_closed;
  int          results_checked;
  int          mismatches;
  int          cycle_count;
  int          burst_left;

  logic signed [ssmv_pkg::READING_W-1:0] list_buf[$];

  task automatic clear_accumulators();
    acc_count   = 0;
    acc_min     = 0;
    acc_max     = 0;
    acc_sum     = 0;
    acc_ssq     = '0;
    acc_dropped = 1'b0;
  endtask

  // Fold one accepted reading into the running statistics; on the last reading
  // of a list, compute the result and queue it.
  task automatic absorb_reading(input logic signed [ssmv_pkg::READING_W-1:0] r,
                                input logic l);
    int        x;
    bit        neg;
    bit [63:0] n;
    bit [63:0] abs_sum;
    bit [63:0] mean_mag;
    bit [63:0] sq_term;
    bit [63:0] sum_term;
    bit [63:0] num;
    bit [63:0] var_q;
    stats_t    res;
    // only the low SAMPLE_WIDTH bits count, as two's complement
    x = int'($signed(r[ssmv_pkg::SAMPLE_WIDTH-1:0]));
    if (acc_count < ssmv_pkg::MAX_READINGS) begin
      if (acc_count == 0) begin
        acc_min = x;
        acc_max = x;
      end else begin
        if (x < acc_min) acc_min = x;
        if (x > acc_max) acc_max = x;
      end
      acc_sum   += longint'(x);
      acc_ssq   += 64'(longint'(x) * longint'(x));
      acc_count += 1;
    end else begin
      // list full: reading dropped, but a last marker still closes the list
      acc_dropped = 1'b1;
    end
    if (l) begin
      n        = 64'(acc_count);
      neg      = acc_sum < 0;
      abs_sum  = neg ? 64'(-acc_sum) : 64'(acc_sum);
      mean_mag = (n != 0) ? abs_sum / n : '0;
      var_q    = '0;
      if (n > 1) begin
        // (n*sum_sq - sum^2) / (n*(n-1)), truncated
        sq_term  = n * acc_ssq;
        sum_term = abs_sum * abs_sum;
        num      = (sq_term >= sum_term) ? sq_term - sum_term : '0;
        var_q    = num / (n * (n - 1));
        if (var_q > 64'd2147483647) var_q = 64'd2147483647;
      end
      res.min_v   = 16'(acc_min);
      res.max_v   = 16'(acc_max);
      res.mean_v  = neg ? 16'(-mean_mag) : 16'(mean_mag);  // toward zero
      res.var_v   = var_q[ssmv_pkg::VAR_W-1:0];
      res.count_v = n[ssmv_pkg::CNT_W-1:0];
      res.ovf     = acc_dropped;
      expected_stats.push_back(res);
      lists_closed++;
      clear_accumulators();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Sender works in bursts; between most bursts valid drops for a random gap.
  // Called at a falling edge, returns at a falling edge.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(4, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  // Present one reading and hold it until the transaction is accepted.
  task automatic send_reading(input logic signed [ssmv_pkg::READING_W-1:0] r,
                              input logic l);
    pace_sender();
    in_valid   <= 1'b1;
    in_reading <= r;
    in_last    <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_reading(r, l);
    readings_sent++;
    @(negedge clk);
  endtask

  // Send list_buf as one list; last marker on the final entry.
  task automatic send_list();
    for (int i = 0; i < list_buf.size(); i++)
      send_reading(list_buf[i], i == list_buf.size() - 1);
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Receiver stall pattern: switches among free-running, light, heavy and
  // long-run stalling at random intervals.
  int stall_mode;
  int mode_left;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(50, 400);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 9) < 3);
      2:       out_stall <= ($urandom_range(0, 9) < 8);
      default: out_stall <= ($urandom_range(0, 31) == 0) ? ~out_stall : out_stall;
    endcase
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    stats_t got;
    stats_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.min_v   = out_min_value;
      got.max_v   = out_max_value;
      got.mean_v  = out_mean_value;
      got.var_v   = out_sample_variance;
      got.count_v = out_reading_count;
      got.ovf     = out_overflowed;
      results_checked++;
      if (expected_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0d] unexpected result: min=%0d max=%0d mean=%0d var=%0d cnt=%0d ovf=%0b",
                   cycle_count, got.min_v, got.max_v, got.mean_v, got.var_v,
                   got.count_v, got.ovf);
      end else begin
        want = expected_stats.pop_front();
        if (got.min_v !== want.min_v || got.max_v !== want.max_v ||
            got.mean_v !== want.mean_v || got.var_v !== want.var_v ||
            got.count_v !== want.count_v || got.ovf !== want.ovf) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("[%0d] result mismatch", cycle_count);
            $display("  exp: min=%0d max=%0d mean=%0d var=%0d cnt=%0d ovf=%0b",
                     want.min_v, want.max_v, want.mean_v, want.var_v,
                     want.count_v, want.ovf);
            $display("  got: min=%0d max=%0d mean=%0d var=%0d cnt=%0d ovf=%0b",
                     got.min_v, got.max_v, got.mean_v, got.var_v,
                     got.count_v, got.ovf);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_stats.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Single-reading lists: variance must be 0, min = max = mean = reading.
  // The four values together toggle every reading bit both ways.
  task automatic test_single_readings();
    list_buf = {16'sh8000}; send_list();
    list_buf = {16'sh7fff}; send_list();
    list_buf = {16'sh0000}; send_list();
    list_buf = {-16'sd1};   send_list();
  endtask

  // Short lists on the range extremes, mean truncation toward zero for
  // negative sums, flat lists, and min/max away from the first reading.
  task automatic test_short_lists();
    list_buf = {16'sh8000, 16'sh7fff};          send_list();  // mean -1/2 -> 0
    list_buf = {-16'sd3, -16'sd2};              send_list();  // mean -5/2 -> -2
    list_buf = {16'sd5, 16'sd6, 16'sd8};        send_list();  // both divides truncate
    list_buf = {16'sh7fff, 16'sh7fff, 16'sh7fff}; send_list();
    list_buf = {16'sh8000, 16'sh8000};          send_list();
    list_buf = {16'sd100, -16'sd200, 16'sd300, -16'sd400, 16'sd1}; send_list();
  endtask

  // Random lists: mostly short, some long. Value styles per list: full-range
  // noise, temperature-like drift around a center, extreme-heavy, and flat.
  task automatic test_random_lists();
    int                                    sent;
    int                                    len;
    int                                    style;
    int                                    pick;
    logic signed [ssmv_pkg::READING_W-1:0] center;
    logic signed [ssmv_pkg::READING_W-1:0] v;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 6)      len = $urandom_range(1, 8);
      else if (pick < 9) len = $urandom_range(9, 40);
      else               len = $urandom_range(41, 300);
      style  = $urandom_range(0, 3);
      center = 16'($urandom());
      for (int i = 0; i < len; i++) begin
        case (style)
          0: v = 16'($urandom());
          1: v = 16'(int'(center) + $urandom_range(0, 1024) - 512);
          2: begin
            case ($urandom_range(0, 4))
              0:       v = 16'sh8000;
              1:       v = 16'sh7fff;
              2:       v = -16'sd1;
              3:       v = 16'sh0000;
              default: v = 16'($urandom());
            endcase
          end
          default: v = center;
        endcase
        send_reading(v, i == len - 1);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_reading = '0;
    in_last    = 1'b0;
    out_stall  = 1'b0;
    stall_mode = 0;
    mode_left  = 0;
    burst_left = 0;
    readings_sent   = 0;
    lists_closed    = 0;
    results_checked = 0;
    mismatches      = 0;
    cycle_count     = 0;
    clear_accumulators();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_single_readings();
    test_short_lists();
    test_random_lists();

    in_valid <= 1'b0;
    in_last  <= 1'b0;

    // every list closed -> wait for its result, then let the block settle
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d readings in %0d lists (extremes, truncation, random lists",
             readings_sent, lists_closed);
    $display("in four value styles); checked %0d results, %0d mismatches",
             results_checked, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/ssmv_pkg.sv
hw/rtl/ssmv_div.sv
hw/rtl/ssmv_dp.sv
hw/rtl/ssmv_ctrl.sv
hw/rtl/sample_stats_min_max_mean_var_core.sv
tb/tb_sample_stats_min_max_mean_var_core.sv
